@@ rtl/rfsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfsd_pkg: shared types and constants of the readout frame sample decoder
// Frame geometry, derived widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package rfsd_pkg;

  // Frame geometry
  localparam int CHIPS        = 4;
  localparam int TIME_BUCKETS = 512;
  localparam int CHANNELS     = 68;

  // Fixed field widths
  localparam int CHIP_W   = 2;
  localparam int CHAN_W   = 7;
  localparam int BUCKET_W = 9;
  localparam int SAMPLE_W = 12;
  localparam int WORD_W   = 32;

  // Per-chip queue capacity and derived widths
  localparam int CHIP_CAP   = TIME_BUCKETS * CHANNELS;
  localparam int FILL_W     = $clog2(CHIP_CAP + 1);
  localparam int MEM_DEPTH  = CHIPS * CHIP_CAP;
  localparam int ADDR_W     = $clog2(MEM_DEPTH + 1);
  localparam int CHIP_SLOTS = 2 ** CHIP_W;

  // Opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic part_push;   // unpack the word straight into a result
    logic full_push;   // append the sample to its chip queue
    logic drain_rd;    // issue the queue read for a drain
    logic drain_wb;    // form the drain result and advance position
  } rfsd_cmd_t;

  // Base address of a chip queue in the sample store
  function automatic logic [ADDR_W-1:0] chip_base(input logic [CHIP_W-1:0] chip);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(chip) * ADDR_W'(CHIP_CAP);
    return base;
  endfunction

endpackage

@@ rtl/rfsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfsd_ctrl: decoder controller
// Holds the mode register, accepts items and sequences the drain read.
// ----------------------------------------------------------------------------
module rfsd_ctrl
  import rfsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      opcode,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output logic      busy,
  output rfsd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   full_readout_r;
  logic   accept;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_readout_r <= 1'b0;
    end else if (cfg_wr_en) begin
      full_readout_r <= cfg_wr_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && opcode == OP_DRAIN) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd.part_push = accept && opcode == OP_PUSH && !full_readout_r;
    cmd.full_push = accept && opcode == OP_PUSH && full_readout_r;
    cmd.drain_rd  = accept && opcode == OP_DRAIN;
    cmd.drain_wb  = (state_r == ST_DRAIN);
  end

endmodule

@@ rtl/rfsd_datapath.sv @@
// ----------------------------------------------------------------------------
// rfsd_datapath: decoder datapath
// Sample store, chip fill counts, drain position and the result register.
// ----------------------------------------------------------------------------
module rfsd_datapath
  import rfsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rfsd_cmd_t           cmd,
  input  logic [WORD_W-1:0]   data_word,
  output logic                out_valid,
  output logic [CHIP_W-1:0]   out_chip_index,
  output logic [CHAN_W-1:0]   out_channel_index,
  output logic [BUCKET_W-1:0] out_time_bucket,
  output logic [SAMPLE_W-1:0] out_sample_value,
  output logic                out_underflow,
  output logic                out_overflow_seen,
  output logic                out_last
);

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [FILL_W-1:0]   fill_r [CHIP_SLOTS];
  logic [CHIP_W-1:0]   drain_chip_r;
  logic [BUCKET_W-1:0] drain_bucket_r;
  logic [CHAN_W-1:0]   drain_chan_r;
  logic [FILL_W-1:0]   read_idx_r;
  logic                overflow_r;

  logic                out_valid_r;
  logic [CHIP_W-1:0]   chip_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                uf_r;
  logic                ovf_r;
  logic                last_r;

  logic [CHIP_W-1:0]   push_chip;
  logic [SAMPLE_W-1:0] push_sample;
  logic [FILL_W-1:0]   push_fill;
  logic                push_ok;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                hit;
  logic                is_last;
  logic                chan_wrap;
  logic                bucket_wrap;

  // Full-mode push decode
  assign push_chip   = data_word[15:14];
  assign push_sample = data_word[SAMPLE_W-1:0];
  assign push_fill   = fill_r[push_chip];
  assign push_ok     = ({1'b0, push_chip} < (CHIP_W+1)'(CHIPS))
                    && (push_fill < FILL_W'(CHIP_CAP));
  assign wr_addr     = chip_base(push_chip) + ADDR_W'(push_fill);
  assign rd_addr     = chip_base(drain_chip_r) + ADDR_W'(read_idx_r);

  // Sample store: one write port for pushes, one registered read for drains
  always_ff @(posedge clk) begin
    if (cmd.full_push && push_ok) begin
      mem[wr_addr] <= push_sample;
    end
    if (cmd.drain_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Drain position decode
  assign hit         = ({1'b0, drain_chip_r} < (CHIP_W+1)'(CHIPS))
                    && (read_idx_r < fill_r[drain_chip_r])
                    && (read_idx_r < FILL_W'(CHIP_CAP));
  assign chan_wrap   = (drain_chan_r >= CHAN_W'(CHANNELS - 1));
  assign bucket_wrap = (drain_bucket_r >= BUCKET_W'(TIME_BUCKETS - 1));
  assign is_last     = (drain_chip_r >= CHIP_W'(CHIPS - 1)) && bucket_wrap && chan_wrap;

  // Fill counts, drain position and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHIP_SLOTS; i++) begin
        fill_r[i] <= '0;
      end
      drain_chip_r   <= '0;
      drain_bucket_r <= '0;
      drain_chan_r   <= '0;
      read_idx_r     <= '0;
      overflow_r     <= 1'b0;
    end else if (cmd.full_push) begin
      if (push_ok) begin
        fill_r[push_chip] <= push_fill + FILL_W'(1);
      end else begin
        overflow_r <= 1'b1;
      end
    end else if (cmd.drain_wb) begin
      if (is_last) begin
        // End of frame: clear fill counts, drain position and overflow for the next one
        for (int i = 0; i < CHIP_SLOTS; i++) begin
          fill_r[i] <= '0;
        end
        drain_chip_r   <= '0;
        drain_bucket_r <= '0;
        drain_chan_r   <= '0;
        read_idx_r     <= '0;
        overflow_r     <= 1'b0;
      end else if (chan_wrap && bucket_wrap) begin
        drain_chan_r   <= '0;
        drain_bucket_r <= '0;
        drain_chip_r   <= drain_chip_r + CHIP_W'(1);
        read_idx_r     <= '0;
      end else if (chan_wrap) begin
        drain_chan_r   <= '0;
        drain_bucket_r <= drain_bucket_r + BUCKET_W'(1);
        read_idx_r     <= read_idx_r + FILL_W'(1);
      end else begin
        drain_chan_r   <= drain_chan_r + CHAN_W'(1);
        read_idx_r     <= read_idx_r + FILL_W'(1);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.part_push || cmd.drain_wb;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.part_push) begin
      chip_r   <= data_word[31:30];
      chan_r   <= data_word[29:23];
      bucket_r <= data_word[22:14];
      sample_r <= data_word[SAMPLE_W-1:0];
      uf_r     <= 1'b0;
      ovf_r    <= overflow_r;
      last_r   <= 1'b0;
    end else if (cmd.drain_wb) begin
      chip_r   <= drain_chip_r;
      chan_r   <= drain_chan_r;
      bucket_r <= drain_bucket_r;
      sample_r <= hit ? rd_data_r : '0;
      uf_r     <= !hit;
      ovf_r    <= overflow_r;
      last_r   <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chip_index    = chip_r;
  assign out_channel_index = chan_r;
  assign out_time_bucket   = bucket_r;
  assign out_sample_value  = sample_r;
  assign out_underflow     = uf_r;
  assign out_overflow_seen = ovf_r;
  assign out_last          = last_r;

endmodule

@@ rtl/readout_frame_sample_decoder.sv @@
// ----------------------------------------------------------------------------
// readout_frame_sample_decoder: top level of the frame sample decoder
// Decodes readout frame data words directly or through per-chip queues.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_opcode and in_data_word with start high; the item is
//   transferred at a clock edge where start is high and busy is low.
//   Result: out_valid is high for exactly one cycle per result, with the
//   result fields alongside; the receiver takes every result, no stall.
//   Config: cfg_wr_en with cfg_wr_data writes full_readout; write it only
//   while no item is in flight.
// Timing:
//   A push leaves busy low, so pushes run one per cycle while no drain is in flight.
//   A partial-mode push gives its result in the cycle after the transfer.
//   A drain reads the sample store into a register, so busy is high for
//   one cycle while the drain state forms the result in the result
//   register.
// Reset:
//   rst_n clears the mode, the chip fill counts, the drain position and
//   the overflow flag. The sample store is not cleared; only entries
//   written in the current frame are ever output.
// ----------------------------------------------------------------------------
module readout_frame_sample_decoder
  import rfsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [WORD_W-1:0]   in_data_word,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                out_valid,
  output logic [CHIP_W-1:0]   out_chip_index,
  output logic [CHAN_W-1:0]   out_channel_index,
  output logic [BUCKET_W-1:0] out_time_bucket,
  output logic [SAMPLE_W-1:0] out_sample_value,
  output logic                out_underflow,
  output logic                out_overflow_seen,
  output logic                out_last
);

  rfsd_cmd_t cmd;

  // Controller
  rfsd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .opcode      (in_opcode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .cmd         (cmd)
  );

  // Datapath
  rfsd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .data_word         (in_data_word),
    .out_valid         (out_valid),
    .out_chip_index    (out_chip_index),
    .out_channel_index (out_channel_index),
    .out_time_bucket   (out_time_bucket),
    .out_sample_value  (out_sample_value),
    .out_underflow     (out_underflow),
    .out_overflow_seen (out_overflow_seen),
    .out_last          (out_last)
  );

endmodule
